FILE: rtl/core/qvr_pkg.sv
// Package for the quaternion vector rotation pipeline.
// Holds the shared widths, latencies and the pipeline control word; depends on nothing.
package qvr_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 17;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 34;
  localparam int TERM_W = 50;
  localparam int NUM_W  = 52;
  localparam int NORM_W = 33;
  localparam int REM_W  = 53;
  localparam int DEN_W  = 34;
  localparam int QUO_W  = 17;

  localparam int NUMER_LAT = 4;
  localparam int DIV_LAT   = QUO_W + 1;

  localparam logic signed [OUT_W:0] ROT_MAX = 18'sd65535;
  localparam logic signed [OUT_W:0] ROT_MIN = -18'sd65536;

  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

endpackage

FILE: rtl/core/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation block.
// Uses qvr_pkg, qvr_numer and qvr_divider.
//
// A word is taken whenever start is high; busy is never raised. Each word gives one result,
// flagged by done for a single cycle, after the multiply-and-add stages, the stages of the
// pipelined divider (one quotient bit a stage after a preparation stage) and one output register.
// A new word may enter every cycle. The receiver cannot stall the block, so results must
// be captured on the cycle that done is high.
module quaternion_vector_rotate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qvr_pkg::IN_W-1:0]    quat_w,
  input  logic signed [qvr_pkg::IN_W-1:0]    quat_x,
  input  logic signed [qvr_pkg::IN_W-1:0]    quat_y,
  input  logic signed [qvr_pkg::IN_W-1:0]    quat_z,
  input  logic signed [qvr_pkg::IN_W-1:0]    vec_x,
  input  logic signed [qvr_pkg::IN_W-1:0]    vec_y,
  input  logic signed [qvr_pkg::IN_W-1:0]    vec_z,
  output logic                               done,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_x,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_y,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_z,
  output logic                               zero_quat_error
);
  import qvr_pkg::*;

  ctl_t                    nctl;
  ctl_t                    cpipe [DIV_LAT];
  logic signed [NUM_W-1:0] num_x, num_y, num_z;
  logic        [NORM_W-1:0] norm;
  logic                    neg_x, neg_y, neg_z;
  logic        [QUO_W-1:0] quo_x, quo_y, quo_z;

  assign busy = 1'b0;

  qvr_numer u_numer (
    .clk, .rst, .in_valid(start),
    .quat_w, .quat_x, .quat_y, .quat_z, .vec_x, .vec_y, .vec_z,
    .ctl(nctl), .num_x, .num_y, .num_z, .norm
  );

  qvr_divider u_div_x (.clk, .num(num_x), .norm, .neg(neg_x), .quo(quo_x));
  qvr_divider u_div_y (.clk, .num(num_y), .norm, .neg(neg_y), .quo(quo_y));
  qvr_divider u_div_z (.clk, .num(num_z), .norm, .neg(neg_z), .quo(quo_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        cpipe[i].valid <= 1'b0;
      end
    end else begin
      cpipe[0].valid <= nctl.valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        cpipe[i].valid <= cpipe[i-1].valid;
      end
    end
    cpipe[0].err <= nctl.err;
    for (int i = 1; i < DIV_LAT; i++) begin
      cpipe[i].err <= cpipe[i-1].err;
    end
  end

  function automatic logic signed [OUT_W-1:0] finish(input logic neg, input logic [QUO_W-1:0] q,
                                                     input logic err);
    logic signed [OUT_W:0] val;
    begin
      val = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (err) begin
        finish = '0;
      end else if (val > ROT_MAX) begin
        finish = ROT_MAX[OUT_W-1:0];
      end else if (val < ROT_MIN) begin
        finish = ROT_MIN[OUT_W-1:0];
      end else begin
        finish = val[OUT_W-1:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cpipe[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    rot_x           <= finish(neg_x, quo_x, cpipe[DIV_LAT-1].err);
    rot_y           <= finish(neg_y, quo_y, cpipe[DIV_LAT-1].err);
    rot_z           <= finish(neg_z, quo_z, cpipe[DIV_LAT-1].err);
    zero_quat_error <= cpipe[DIV_LAT-1].err;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && zero_quat_error |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
    else $error("zero quaternion word gave a nonzero vector");

  a_done_follows_pipe: assert property (@(posedge clk) disable iff (rst)
    cpipe[DIV_LAT-1].valid |=> done)
    else $error("word leaving the divider did not raise done");

endmodule

FILE: rtl/core/qvr_numer.sv
// Four-stage numerator pipeline: products, sums, second products and the final numerators.
// Depends on qvr_pkg.
module qvr_numer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [qvr_pkg::IN_W-1:0]      quat_w,
  input  logic signed [qvr_pkg::IN_W-1:0]      quat_x,
  input  logic signed [qvr_pkg::IN_W-1:0]      quat_y,
  input  logic signed [qvr_pkg::IN_W-1:0]      quat_z,
  input  logic signed [qvr_pkg::IN_W-1:0]      vec_x,
  input  logic signed [qvr_pkg::IN_W-1:0]      vec_y,
  input  logic signed [qvr_pkg::IN_W-1:0]      vec_z,
  output qvr_pkg::ctl_t                        ctl,
  output logic signed [qvr_pkg::NUM_W-1:0]     num_x,
  output logic signed [qvr_pkg::NUM_W-1:0]     num_y,
  output logic signed [qvr_pkg::NUM_W-1:0]     num_z,
  output logic        [qvr_pkg::NORM_W-1:0]    norm
);
  import qvr_pkg::*;

  logic [NUMER_LAT-1:0] valid;
  logic                 zero_n;

  logic signed [IN_W-1:0]   w1, x1, y1, z1, vx1, vy1, vz1;
  logic signed [PROD_W-1:0] ww, xx, yy, zz, xvx, yvy, zvz, yvz, zvy, zvx, xvz, xvy, yvx;

  logic signed [IN_W-1:0]   w2, x2, y2, z2, vx2, vy2, vz2;
  logic signed [SUM_W-1:0]  n2, uv2, k2, cx2, cy2, cz2;

  logic signed [TERM_W-1:0] ax, ay, az, bx, by, bz, cx3, cy3, cz3;
  logic signed [SUM_W-1:0]  n3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[NUMER_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    w1  <= quat_w;
    x1  <= quat_x;
    y1  <= quat_y;
    z1  <= quat_z;
    vx1 <= vec_x;
    vy1 <= vec_y;
    vz1 <= vec_z;
    ww  <= quat_w * quat_w;
    xx  <= quat_x * quat_x;
    yy  <= quat_y * quat_y;
    zz  <= quat_z * quat_z;
    xvx <= quat_x * vec_x;
    yvy <= quat_y * vec_y;
    zvz <= quat_z * vec_z;
    yvz <= quat_y * vec_z;
    zvy <= quat_z * vec_y;
    zvx <= quat_z * vec_x;
    xvz <= quat_x * vec_z;
    xvy <= quat_x * vec_y;
    yvx <= quat_y * vec_x;
  end

  always_ff @(posedge clk) begin
    w2  <= w1;
    x2  <= x1;
    y2  <= y1;
    z2  <= z1;
    vx2 <= vx1;
    vy2 <= vy1;
    vz2 <= vz1;
    n2  <= SUM_W'(ww) + SUM_W'(xx) + SUM_W'(yy) + SUM_W'(zz);
    k2  <= SUM_W'(ww) - SUM_W'(xx) - SUM_W'(yy) - SUM_W'(zz);
    uv2 <= SUM_W'(xvx) + SUM_W'(yvy) + SUM_W'(zvz);
    cx2 <= SUM_W'(yvz) - SUM_W'(zvy);
    cy2 <= SUM_W'(zvx) - SUM_W'(xvz);
    cz2 <= SUM_W'(xvy) - SUM_W'(yvx);
  end

  always_ff @(posedge clk) begin
    n3  <= n2;
    ax  <= uv2 * x2;
    ay  <= uv2 * y2;
    az  <= uv2 * z2;
    bx  <= k2 * vx2;
    by  <= k2 * vy2;
    bz  <= k2 * vz2;
    cx3 <= cx2 * w2;
    cy3 <= cy2 * w2;
    cz3 <= cz2 * w2;
  end

  always_ff @(posedge clk) begin
    norm   <= n3[NORM_W-1:0];
    zero_n <= (n3 == '0);
    num_x  <= (NUM_W'(ax) <<< 1) + NUM_W'(bx) - (NUM_W'(cx3) <<< 1);
    num_y  <= (NUM_W'(ay) <<< 1) + NUM_W'(by) - (NUM_W'(cy3) <<< 1);
    num_z  <= (NUM_W'(az) <<< 1) + NUM_W'(bz) - (NUM_W'(cz3) <<< 1);
  end

  assign ctl = '{valid: valid[NUMER_LAT-1], err: zero_n};

endmodule

FILE: rtl/core/qvr_divider.sv
// Pipelined restoring divider for one lane, rounding to nearest with halves away from zero.
// One quotient bit per stage after a preparation stage; depends on qvr_pkg.
module qvr_divider (
  input  logic                               clk,
  input  logic signed [qvr_pkg::NUM_W-1:0]   num,
  input  logic        [qvr_pkg::NORM_W-1:0]  norm,
  output logic                               neg,
  output logic        [qvr_pkg::QUO_W-1:0]   quo
);
  import qvr_pkg::*;

  logic [REM_W-1:0] rem [QUO_W+1];
  logic [DEN_W-1:0] den [QUO_W+1];
  logic [QUO_W-1:0] q   [QUO_W+1];
  logic             sgn [QUO_W+1];
  logic [NUM_W-1:0] mag;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    rem[0] <= {mag, 1'b0} + REM_W'(norm);
    den[0] <= {norm, 1'b0};
    q[0]   <= '0;
    sgn[0] <= num[NUM_W-1];
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int SH = QUO_W - 1 - i;
    logic [REM_W-1:0] sub;
    assign sub = REM_W'(den[i]) << SH;
    always_ff @(posedge clk) begin
      if (rem[i] >= sub) begin
        rem[i+1] <= rem[i] - sub;
        q[i+1]   <= q[i] | (QUO_W'(1) << SH);
      end else begin
        rem[i+1] <= rem[i];
        q[i+1]   <= q[i];
      end
      den[i+1] <= den[i];
      sgn[i+1] <= sgn[i];
    end
  end

  assign quo = q[QUO_W];
  assign neg = sgn[QUO_W];

endmodule

FILE: bench/tb_quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Self-checking bench for quaternion_vector_rotate: directed and random rotations,
// predicted in exact integer arithmetic and compared word by word. Depends on qvr_pkg.
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [IN_W-1:0] qw, qx, qy, qz, vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x, y, z;
    logic err;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_quat_error;
  logic signed [IN_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic signed [IN_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [OUT_W-1:0] rot_x, rot_y, rot_z;

  rot_req_t pending_words[$];
  rot_res_t expected_rots[$];
  int errors = 0;
  bit drain_hold = 1'b0;
  bit calm = 1'b0;
  int sent = 0;

  always #10 clk = ~clk;

  quaternion_vector_rotate u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .zero_quat_error(zero_quat_error)
  );

  function automatic logic signed [63:0] round_div(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = num < 0 ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp17(input logic signed [63:0] r);
    if (r > 65535) return 17'sd65535;
    if (r < -65536) return -17'sd65536;
    return r[OUT_W-1:0];
  endfunction

  function automatic rot_res_t rotate_vector(input rot_req_t a);
    logic signed [63:0] w, ux, uy, uz, vx, vy, vz, uu, n, uv, k, cx, cy, cz;
    rot_res_t r;
    w = a.qw; ux = a.qx; uy = a.qy; uz = a.qz; vx = a.vx; vy = a.vy; vz = a.vz;
    uu = ux * ux + uy * uy + uz * uz;
    n = w * w + uu;
    if (n == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.err = 1'b1;
      return r;
    end
    uv = ux * vx + uy * vy + uz * vz;
    k = w * w - uu;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    r.x = clamp17(round_div(2 * uv * ux + k * vx - 2 * w * cx, n));
    r.y = clamp17(round_div(2 * uv * uy + k * vy - 2 * w * cy, n));
    r.z = clamp17(round_div(2 * uv * uz + k * vz - 2 * w * cz, n));
    r.err = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rots.push_back(rotate_vector({quat_w, quat_x, quat_y, quat_z,
                                               vec_x, vec_y, vec_z}));
        sent = sent + 1;
      end
      if (!(start && busy) && pending_words.size() > 0 && !drain_hold
          && (calm || $urandom_range(99) >= 32)) begin
        rot_req_t nxt;
        nxt = pending_words.pop_front();
        start <= 1'b1;
        {quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z} <= nxt;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rots.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d err=%0b",
                 $time, rot_x, rot_y, rot_z, zero_quat_error);
        errors = errors + 1;
      end else begin
        rot_res_t e;
        e = expected_rots.pop_front();
        if (rot_x !== e.x || rot_y !== e.y || rot_z !== e.z
            || zero_quat_error !== e.err) begin
          $display("%0t: expected x=%0d y=%0d z=%0d err=%0b, got x=%0d y=%0d z=%0d err=%0b",
                   $time, e.x, e.y, e.z, e.err, rot_x, rot_y, rot_z, zero_quat_error);
          errors = errors + 1;
        end
      end
    end
  end

  function automatic logic signed [IN_W-1:0] rnd16();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(32)) - 16'sd16);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  initial begin
    rot_req_t it;
    int n_dir;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    pending_words.push_back('{0, 0, 0, 0, 100, -200, 300});
    pending_words.push_back('{0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 0});
    pending_words.push_back('{16384, 0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    pending_words.push_back('{16'sh8000, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_words.push_back('{0, 16384, 0, 0, 1, 2, 3});
    pending_words.push_back('{0, 0, 16384, 0, 16'sh8000, 16'sh7FFF, 16'sh8000});
    pending_words.push_back('{0, 0, 0, 16384, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    pending_words.push_back('{11585, 0, 0, 11585, 16'sh7FFF, 0, 0});
    pending_words.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 5, 16'sh7FFF});
    pending_words.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1});
    pending_words.push_back('{1, 0, 0, 0, 7, -7, 1});
    pending_words.push_back('{0, 1, 1, 0, 1, -1, 1});
    pending_words.push_back('{3, 1, 0, 0, 16'sh8000, 3, 1});
    pending_words.push_back('{16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, -1, -1, -1});
    pending_words.push_back('{0, 0, 0, 1, 16'sh7FFF, 16'sh8000, 0});
    n_dir = pending_words.size();
    wait (pending_words.size() == 0);
    drain_hold = 1'b1;
    wait (sent == n_dir && expected_rots.size() == 0);
    drain_hold = 1'b0;
    for (int i = 0; i < 2000; i++) begin
      it = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
      pending_words.push_back(it);
    end
    calm = 1'b1;
    wait (pending_words.size() < 1700);
    calm = 1'b0;
    wait (pending_words.size() == 0);
    wait (expected_rots.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[quaternion_vector_rotate] OK");
    end else begin
      $display("[quaternion_vector_rotate] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[quaternion_vector_rotate] ERROR");
    $finish;
  end
endmodule
